@@ hdl/mpfb_pkg.sv @@
// Shared constants and types for the monochrome page framebuffer draw engine.
// Used by mono_page_framebuffer_draw. No dependencies.
package mpfb_pkg;

  // Display geometry
  localparam int DISPLAY_WIDTH  = 128;
  localparam int DISPLAY_HEIGHT = 64;
  localparam int PAGE_COUNT     = (DISPLAY_HEIGHT + 7) / 8;
  localparam int STORE_BYTES    = DISPLAY_WIDTH * PAGE_COUNT;

  localparam int COL_W  = (DISPLAY_WIDTH > 1) ? $clog2(DISPLAY_WIDTH) : 1;
  localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int ADDR_W = $clog2(STORE_BYTES);

  // Bounds arithmetic: 16-bit fields plus a 16-bit extent, kept without wrap
  localparam int BND_W = 18;
  typedef logic signed [BND_W-1:0] bnd_t;

  localparam bnd_t COL_LIMIT = bnd_t'(DISPLAY_WIDTH);
  localparam bnd_t ROW_LIMIT = bnd_t'(DISPLAY_HEIGHT);

  typedef logic [COL_W-1:0]  col_t;
  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // Command kinds
  localparam logic [2:0] KIND_FILL  = 3'd0;
  localparam logic [2:0] KIND_PIXEL = 3'd1;
  localparam logic [2:0] KIND_HLINE = 3'd2;
  localparam logic [2:0] KIND_VLINE = 3'd3;
  localparam logic [2:0] KIND_RECT  = 3'd4;
  localparam logic [2:0] KIND_READ  = 3'd5;

  // Color codes
  localparam logic [1:0] COLOR_BLACK   = 2'd0;
  localparam logic [1:0] COLOR_WHITE   = 2'd1;
  localparam logic [1:0] COLOR_INVERSE = 2'd2;

  localparam logic [7:0] BYTE_ONES  = 8'hFF;
  localparam logic [7:0] BYTE_ZEROS = 8'h00;

endpackage

@@ hdl/mpfb_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mpfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/mono_page_framebuffer_draw.sv @@
// Top level of the monochrome page framebuffer draw engine.
// Depends on mpfb_pkg and mpfb_ram.
//
//  channel | dir | handshake                       | payload
//  --------+-----+---------------------------------+-----------------------------------------
//  command | in  | start, busy (taken: start&!busy) | kind_i x_i y_i length_i height_i color_i
//  result  | out | read_valid_o strobe, 1 cycle    | read_data_o
//  config  | in  | cfg_valid_i / cfg_ready_o       | cfg_data_i (invert_pixels)
//
// Every drawing command becomes a clipped rectangle of columns by rows. The walker visits
// each touched byte once (columns outer, pages inner), one byte per cycle, as a
// read-modify-write on the frame RAM, once ST_SETUP has clipped the bounds.
// A read passes through ST_RD and ST_RDOUT, then gives its one-cycle strobe; kinds 6 and 7 are taken and dropped.
// After reset the engine clears the RAM with the same walker, and busy stays high until
// that walk is done. Config writes are taken at any time.
// Results cannot be stalled; the strobe is registered and never blocks the next command.
module mono_page_framebuffer_draw (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               start,
  output logic               busy,
  input  logic [2:0]         kind_i,
  input  logic signed [15:0] x_i,
  input  logic signed [15:0] y_i,
  input  logic signed [15:0] length_i,
  input  logic signed [15:0] height_i,
  input  logic [1:0]         color_i,

  output logic               read_valid_o,
  output logic [7:0]         read_data_o,

  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_RD,
    ST_RDOUT
  } state_e;

  typedef enum logic [1:0] {
    OP_CLR,
    OP_SET,
    OP_TOG,
    OP_NONE
  } op_e;

  state_e state_q;
  op_e    op_q;
  logic   invert_q;

  // Unclamped bounds, end exclusive
  mpfb_pkg::bnd_t cs_q, ce_q, rs_q, re_q;

  // Walker
  mpfb_pkg::col_t  col_q, c_last_q;
  mpfb_pkg::page_t page_q, p_first_q, p_last_q;
  logic [2:0]      lo_first_q, hi_last_q;

  // Write-back stage of the read-modify-write
  logic            wr_valid_q;
  mpfb_pkg::addr_t wr_addr_q;
  logic [7:0]      wr_mask_q;

  // Read command
  mpfb_pkg::addr_t rd_addr_q;
  logic            rd_hit_q;
  logic            read_valid_q;
  logic [7:0]      read_data_q;

  logic            accept;
  op_e             color_op;
  mpfb_pkg::bnd_t  x_ext, y_ext, len_ext, h_ext;
  mpfb_pkg::bnd_t  c0, c1, r0, r1, c1m, r1m;
  logic            region_empty;
  mpfb_pkg::addr_t walk_addr, ram_raddr;
  logic [2:0]      mask_lo, mask_hi;
  logic [7:0]      walk_mask;
  logic [7:0]      ram_rdata, ram_wdata;
  logic            in_range;

  assign accept      = start && (state_q == ST_IDLE);
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign read_valid_o = read_valid_q;
  assign read_data_o  = read_data_q;

  assign x_ext   = mpfb_pkg::bnd_t'(x_i);
  assign y_ext   = mpfb_pkg::bnd_t'(y_i);
  assign len_ext = mpfb_pkg::bnd_t'(length_i);
  assign h_ext   = mpfb_pkg::bnd_t'(height_i);

  always_comb begin
    case (color_i)
      mpfb_pkg::COLOR_BLACK:   color_op = OP_CLR;
      mpfb_pkg::COLOR_WHITE:   color_op = OP_SET;
      mpfb_pkg::COLOR_INVERSE: color_op = OP_TOG;
      default:                 color_op = OP_NONE;
    endcase
  end

  assign in_range = (x_i >= 0) && (x_ext < mpfb_pkg::COL_LIMIT) &&
                    (y_i >= 0) && (y_ext < mpfb_pkg::ROW_LIMIT);

  // Clip against the display
  always_comb begin
    c0 = (cs_q < 0) ? '0 : cs_q;
    c1 = (ce_q > mpfb_pkg::COL_LIMIT) ? mpfb_pkg::COL_LIMIT : ce_q;
    r0 = (rs_q < 0) ? '0 : rs_q;
    r1 = (re_q > mpfb_pkg::ROW_LIMIT) ? mpfb_pkg::ROW_LIMIT : re_q;
    c1m = c1 - mpfb_pkg::bnd_t'(1);
    r1m = r1 - mpfb_pkg::bnd_t'(1);
    region_empty = (c1 <= c0) || (r1 <= r0) || (op_q == OP_NONE);
  end

  // Byte mask for the current page: head mask on the first page, tail on the last
  always_comb begin
    mask_lo = (page_q == p_first_q) ? lo_first_q : 3'd0;
    mask_hi = (page_q == p_last_q) ? hi_last_q : 3'd7;
    for (int b = 0; b < 8; b++) begin
      walk_mask[b] = (3'(b) >= mask_lo) && (3'(b) <= mask_hi);
    end
  end

  assign walk_addr = mpfb_pkg::addr_t'(mpfb_pkg::addr_t'(page_q) *
                     mpfb_pkg::addr_t'(mpfb_pkg::DISPLAY_WIDTH)) +
                     mpfb_pkg::addr_t'(col_q);
  assign ram_raddr = (state_q == ST_WALK) ? walk_addr : rd_addr_q;

  always_comb begin
    case (op_q)
      OP_CLR:  ram_wdata = ram_rdata & ~wr_mask_q;
      OP_SET:  ram_wdata = ram_rdata | wr_mask_q;
      OP_TOG:  ram_wdata = ram_rdata ^ wr_mask_q;
      default: ram_wdata = ram_rdata;
    endcase
  end

  mpfb_ram #(
    .WIDTH (8),
    .DEPTH (mpfb_pkg::STORE_BYTES)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (wr_valid_q),
    .waddr_i (wr_addr_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // Reset clears the store through the walker
      state_q      <= ST_SETUP;
      op_q         <= OP_CLR;
      cs_q         <= '0;
      ce_q         <= mpfb_pkg::COL_LIMIT;
      rs_q         <= '0;
      re_q         <= mpfb_pkg::ROW_LIMIT;
      invert_q     <= 1'b0;
      wr_valid_q   <= 1'b0;
      read_valid_q <= 1'b0;
      read_data_q  <= mpfb_pkg::BYTE_ZEROS;
      col_q        <= '0;
      page_q       <= '0;
      c_last_q     <= '0;
      p_first_q    <= '0;
      p_last_q     <= '0;
      lo_first_q   <= '0;
      hi_last_q    <= '0;
      wr_addr_q    <= '0;
      wr_mask_q    <= '0;
      rd_addr_q    <= '0;
      rd_hit_q     <= 1'b0;
    end else begin
      read_valid_q <= 1'b0;
      wr_valid_q   <= 1'b0;

      if (cfg_valid_i) begin
        invert_q <= cfg_data_i;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (kind_i)
              mpfb_pkg::KIND_FILL: begin
                cs_q    <= '0;
                ce_q    <= mpfb_pkg::COL_LIMIT;
                rs_q    <= '0;
                re_q    <= mpfb_pkg::ROW_LIMIT;
                op_q    <= (color_i == mpfb_pkg::COLOR_BLACK) ? OP_CLR : OP_SET;
                state_q <= ST_SETUP;
              end
              mpfb_pkg::KIND_PIXEL: begin
                cs_q    <= x_ext;
                ce_q    <= x_ext + mpfb_pkg::bnd_t'(1);
                rs_q    <= y_ext;
                re_q    <= y_ext + mpfb_pkg::bnd_t'(1);
                op_q    <= (invert_q ? (color_i == mpfb_pkg::COLOR_BLACK)
                                     : (color_i == mpfb_pkg::COLOR_WHITE)) ? OP_SET : OP_CLR;
                state_q <= ST_SETUP;
              end
              mpfb_pkg::KIND_HLINE: begin
                cs_q    <= x_ext;
                ce_q    <= x_ext + len_ext;
                rs_q    <= y_ext;
                re_q    <= y_ext + mpfb_pkg::bnd_t'(1);
                op_q    <= color_op;
                state_q <= ST_SETUP;
              end
              mpfb_pkg::KIND_VLINE: begin
                cs_q    <= x_ext;
                ce_q    <= x_ext + mpfb_pkg::bnd_t'(1);
                rs_q    <= y_ext;
                re_q    <= y_ext + len_ext;
                op_q    <= color_op;
                state_q <= ST_SETUP;
              end
              mpfb_pkg::KIND_RECT: begin
                cs_q    <= x_ext;
                ce_q    <= x_ext + len_ext;
                rs_q    <= y_ext;
                re_q    <= y_ext + h_ext;
                op_q    <= color_op;
                state_q <= ST_SETUP;
              end
              mpfb_pkg::KIND_READ: begin
                rd_hit_q  <= in_range;
                rd_addr_q <= mpfb_pkg::addr_t'(
                               mpfb_pkg::addr_t'(mpfb_pkg::page_t'(y_i >>> 3)) *
                               mpfb_pkg::addr_t'(mpfb_pkg::DISPLAY_WIDTH)) +
                             mpfb_pkg::addr_t'(mpfb_pkg::col_t'(x_i));
                state_q   <= ST_RD;
              end
              default: begin
                // unused kinds: taken, nothing done
              end
            endcase
          end
        end

        ST_SETUP: begin
          if (region_empty) begin
            state_q <= ST_IDLE;
          end else begin
            c_last_q   <= mpfb_pkg::col_t'(c1m);
            p_first_q  <= mpfb_pkg::page_t'(r0 >>> 3);
            p_last_q   <= mpfb_pkg::page_t'(r1m >>> 3);
            lo_first_q <= r0[2:0];
            hi_last_q  <= r1m[2:0];
            col_q      <= mpfb_pkg::col_t'(c0);
            page_q     <= mpfb_pkg::page_t'(r0 >>> 3);
            state_q    <= ST_WALK;
          end
        end

        ST_WALK: begin
          // read issued this cycle, written back next cycle
          wr_valid_q <= 1'b1;
          wr_addr_q  <= walk_addr;
          wr_mask_q  <= walk_mask;
          if (page_q == p_last_q) begin
            page_q <= p_first_q;
            if (col_q == c_last_q) begin
              state_q <= ST_IDLE;
            end else begin
              col_q <= col_q + mpfb_pkg::col_t'(1);
            end
          end else begin
            page_q <= page_q + mpfb_pkg::page_t'(1);
          end
        end

        ST_RD: begin
          state_q <= ST_RDOUT;
        end

        ST_RDOUT: begin
          read_valid_q <= 1'b1;
          read_data_q  <= rd_hit_q ? ram_rdata : mpfb_pkg::BYTE_ZEROS;
          state_q      <= ST_IDLE;
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// Testbench for mono_page_framebuffer_draw: random and directed draw commands,
// with a byte-level framebuffer predictor that checks every read result.
// Depends on mpfb_pkg and the RTL of the draw engine.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Command kinds the engine takes and drops without effect, and the unused color code
  localparam logic [2:0] KIND_SPARE_6 = 3'd6;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;
  localparam logic [1:0] COLOR_NONE   = 2'd3;

  typedef struct {
    logic [2:0]         kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] length;
    logic signed [15:0] height;
    logic [1:0]         color;
  } draw_cmd_t;

  // Byte store predictor plus the queue of read bytes still owed by the engine.
  class frame_scoreboard;
    logic [7:0] frame [mpfb_pkg::STORE_BYTES];
    logic       invert;
    logic [7:0] read_bytes_due [$];
    int         errors;

    function new();
      foreach (frame[i]) frame[i] = mpfb_pkg::BYTE_ZEROS;
      invert = 1'b0;
      errors = 0;
    endfunction

    function void set_invert(logic v);
      invert = v;
    endfunction

    function int pending();
      return read_bytes_due.size();
    endfunction

    function void paint(int idx, logic [7:0] mask, logic [1:0] color);
      if (idx < 0 || idx >= mpfb_pkg::STORE_BYTES) return;
      case (color)
        mpfb_pkg::COLOR_BLACK:   frame[idx] = frame[idx] & ~mask;
        mpfb_pkg::COLOR_WHITE:   frame[idx] = frame[idx] | mask;
        mpfb_pkg::COLOR_INVERSE: frame[idx] = frame[idx] ^ mask;
        default: ;
      endcase
    endfunction

    // One column, clipped; head mask, whole bytes, tail mask.
    function void paint_column(int col, int row0, int rows, logic [1:0] color);
      int row_end, r, page, lo, hi;
      logic [7:0] mask;
      if (col < 0 || col >= mpfb_pkg::DISPLAY_WIDTH) return;
      if (row0 < 0) begin
        rows += row0;
        row0 = 0;
      end
      if (row0 + rows > mpfb_pkg::DISPLAY_HEIGHT) rows = mpfb_pkg::DISPLAY_HEIGHT - row0;
      if (rows <= 0) return;
      row_end = row0 + rows;
      r = row0;
      while (r < row_end) begin
        page = r / 8;
        lo   = r % 8;
        hi   = row_end - page * 8;
        if (hi > 8) hi = 8;
        mask = 8'(((1 << hi) - 1) & ~((1 << lo) - 1));
        paint(page * mpfb_pkg::DISPLAY_WIDTH + col, mask, color);
        r = page * 8 + 8;
      end
    endfunction

    function void paint_row(int col0, int row, int cols, logic [1:0] color);
      if (row < 0 || row >= mpfb_pkg::DISPLAY_HEIGHT) return;
      if (col0 < 0) begin
        cols += col0;
        col0 = 0;
      end
      if (col0 + cols > mpfb_pkg::DISPLAY_WIDTH) cols = mpfb_pkg::DISPLAY_WIDTH - col0;
      for (int i = 0; i < cols; i++)
        paint((row / 8) * mpfb_pkg::DISPLAY_WIDTH + col0 + i, 8'(1 << (row % 8)), color);
    endfunction

    // Called for every accepted command transaction.
    function void take_command(draw_cmd_t c);
      int x, y, len, h, c_lo, c_hi;
      logic white;
      logic [7:0] value;
      x   = int'(c.x);
      y   = int'(c.y);
      len = int'(c.length);
      h   = int'(c.height);
      case (c.kind)
        mpfb_pkg::KIND_FILL: begin
          foreach (frame[i])
            frame[i] = (c.color == mpfb_pkg::COLOR_BLACK) ? mpfb_pkg::BYTE_ZEROS
                                                           : mpfb_pkg::BYTE_ONES;
        end
        mpfb_pkg::KIND_PIXEL: begin
          if (x >= 0 && x < mpfb_pkg::DISPLAY_WIDTH &&
              y >= 0 && y < mpfb_pkg::DISPLAY_HEIGHT) begin
            white = invert ? (c.color == mpfb_pkg::COLOR_BLACK)
                           : (c.color == mpfb_pkg::COLOR_WHITE);
            paint((y / 8) * mpfb_pkg::DISPLAY_WIDTH + x, 8'(1 << (y % 8)),
                  white ? mpfb_pkg::COLOR_WHITE : mpfb_pkg::COLOR_BLACK);
          end
        end
        mpfb_pkg::KIND_HLINE: paint_row(x, y, len, c.color);
        mpfb_pkg::KIND_VLINE: paint_column(x, y, len, c.color);
        mpfb_pkg::KIND_RECT: begin
          c_lo = (x < 0) ? 0 : x;
          c_hi = (x + len > mpfb_pkg::DISPLAY_WIDTH) ? mpfb_pkg::DISPLAY_WIDTH : x + len;
          for (int col = c_lo; col < c_hi; col++) paint_column(col, y, h, c.color);
        end
        mpfb_pkg::KIND_READ: begin
          value = mpfb_pkg::BYTE_ZEROS;
          if (x >= 0 && x < mpfb_pkg::DISPLAY_WIDTH &&
              y >= 0 && y < mpfb_pkg::DISPLAY_HEIGHT)
            value = frame[(y / 8) * mpfb_pkg::DISPLAY_WIDTH + x];
          read_bytes_due.push_back(value);
        end
        default: ;
      endcase
    endfunction

    // Called for every read result transaction.
    function void check_byte(logic [7:0] got);
      logic [7:0] want;
      if (read_bytes_due.size() == 0) begin
        $error("read_data: expected none, actual %02h", got);
        errors++;
        return;
      end
      want = read_bytes_due.pop_front();
      if (got !== want) begin
        $error("read_data: expected %02h, actual %02h", want, got);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         kind_i = mpfb_pkg::KIND_FILL;
  logic signed [15:0] x_i = '0;
  logic signed [15:0] y_i = '0;
  logic signed [15:0] length_i = '0;
  logic signed [15:0] height_i = '0;
  logic [1:0]         color_i = mpfb_pkg::COLOR_BLACK;
  logic               read_valid_o;
  logic [7:0]         read_data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_data_i = 1'b0;

  frame_scoreboard model = new();
  draw_cmd_t       prev_cmd;
  bit              no_gaps = 1'b0;

  mono_page_framebuffer_draw dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .kind_i       (kind_i),
    .x_i          (x_i),
    .y_i          (y_i),
    .length_i     (length_i),
    .height_i     (height_i),
    .color_i      (color_i),
    .read_valid_o (read_valid_o),
    .read_data_o  (read_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Results can't be stalled: every strobe cycle is one read transaction.
  always @(posedge clk_i) begin
    if (rst_ni && read_valid_o === 1'b1) model.check_byte(read_data_o);
  end

  function automatic draw_cmd_t cmd(logic [2:0] kind, int x, int y, int len, int h,
                                    logic [1:0] color);
    draw_cmd_t c;
    c.kind   = kind;
    c.x      = 16'(x);
    c.y      = 16'(y);
    c.length = 16'(len);
    c.height = 16'(h);
    c.color  = color;
    return c;
  endfunction

  // Mostly near the display, one time in ten anywhere in the 16-bit range.
  function automatic logic signed [15:0] near_span(int lo, int hi);
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, hi - lo)) + lo);
  endfunction

  function automatic draw_cmd_t random_cmd();
    draw_cmd_t c;
    int pick;
    pick     = $urandom_range(0, 99);
    c.x      = near_span(-8, mpfb_pkg::DISPLAY_WIDTH + 7);
    c.y      = near_span(-8, mpfb_pkg::DISPLAY_HEIGHT + 7);
    c.length = near_span(-4, 40);
    c.height = near_span(-4, 24);
    c.color  = 2'($urandom_range(0, 3));
    if (pick < 2)       c.kind = mpfb_pkg::KIND_FILL;
    else if (pick < 26) c.kind = mpfb_pkg::KIND_PIXEL;
    else if (pick < 42) c.kind = mpfb_pkg::KIND_HLINE;
    else if (pick < 58) c.kind = mpfb_pkg::KIND_VLINE;
    else if (pick < 68) c.kind = mpfb_pkg::KIND_RECT;
    else if (pick < 97) c.kind = mpfb_pkg::KIND_READ;
    else                c.kind = $urandom_range(0, 1) ? KIND_SPARE_6 : KIND_SPARE_7;
    // Half the reads look right next to the last draw, where damage is likely.
    if (c.kind == mpfb_pkg::KIND_READ && $urandom_range(0, 1)) begin
      c.x = prev_cmd.x + 16'(int'($urandom_range(0, 2)) - 1);
      c.y = prev_cmd.y + 16'(int'($urandom_range(0, 4)) - 2);
    end
    return c;
  endfunction

  // One command transaction, then a random sender gap. start stays high when
  // no gap follows, so it is never dropped and raised within one step.
  task automatic send_cmd(input draw_cmd_t c);
    int gap, r;
    start    <= 1'b1;
    kind_i   <= c.kind;
    x_i      <= c.x;
    y_i      <= c.y;
    length_i <= c.length;
    height_i <= c.height;
    color_i  <= c.color;
    do @(posedge clk_i); while (busy !== 1'b0);
    model.take_command(c);
    if (c.kind != mpfb_pkg::KIND_READ) prev_cmd = c;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) gap = 0;
    else if (r < 90)       gap = $urandom_range(1, 3);
    else                   gap = $urandom_range(8, 60);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Sender holds off until all reads are back, then lets a full-store walk
  // finish, since drawing commands give no sign of completion.
  task automatic settle();
    start <= 1'b0;
    while (model.pending() != 0) @(posedge clk_i);
    repeat (mpfb_pkg::STORE_BYTES + 8) @(posedge clk_i);
  endtask

  task automatic write_invert(input logic v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    model.set_invert(v);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    prev_cmd = cmd(mpfb_pkg::KIND_PIXEL, 0, 0, 0, 0, mpfb_pkg::COLOR_WHITE);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_invert(1'b0);

    // Directed: corners, clipping, masks, dead color, unused kinds, fills.
    send_cmd(cmd(mpfb_pkg::KIND_READ, 0, 0, 0, 0, mpfb_pkg::COLOR_BLACK)); // cleared at reset
    send_cmd(cmd(mpfb_pkg::KIND_PIXEL, 0, 0, 0, 0, mpfb_pkg::COLOR_WHITE));
    send_cmd(cmd(mpfb_pkg::KIND_READ, 0, 0, 0, 0, mpfb_pkg::COLOR_BLACK));
    send_cmd(cmd(mpfb_pkg::KIND_PIXEL, mpfb_pkg::DISPLAY_WIDTH - 1,
                 mpfb_pkg::DISPLAY_HEIGHT - 1, 0, 0, mpfb_pkg::COLOR_WHITE));
    send_cmd(cmd(mpfb_pkg::KIND_READ, mpfb_pkg::DISPLAY_WIDTH - 1,
                 mpfb_pkg::DISPLAY_HEIGHT - 1, 0, 0, mpfb_pkg::COLOR_BLACK));
    send_cmd(cmd(mpfb_pkg::KIND_PIXEL, -1, 5, 0, 0, mpfb_pkg::COLOR_WHITE)); // off screen
    send_cmd(cmd(mpfb_pkg::KIND_PIXEL, mpfb_pkg::DISPLAY_WIDTH, 0, 0, 0,
                 mpfb_pkg::COLOR_WHITE));
    send_cmd(cmd(mpfb_pkg::KIND_HLINE, -5, 10, 10, 0, mpfb_pkg::COLOR_WHITE)); // left clip
    send_cmd(cmd(mpfb_pkg::KIND_READ, 4, 10, 0, 0, mpfb_pkg::COLOR_BLACK));
    send_cmd(cmd(mpfb_pkg::KIND_VLINE, 3, 5, 20, 0, mpfb_pkg::COLOR_INVERSE)); // head, tail
    send_cmd(cmd(mpfb_pkg::KIND_READ, 3, 16, 0, 0, mpfb_pkg::COLOR_BLACK));
    send_cmd(cmd(mpfb_pkg::KIND_READ, 3, 24, 0, 0, mpfb_pkg::COLOR_BLACK));
    send_cmd(cmd(mpfb_pkg::KIND_VLINE, 10, -3, 70, 0, mpfb_pkg::COLOR_WHITE)); // both ends
    send_cmd(cmd(mpfb_pkg::KIND_RECT, 120, 60, 20, 10, mpfb_pkg::COLOR_WHITE)); // corner
    send_cmd(cmd(mpfb_pkg::KIND_READ, mpfb_pkg::DISPLAY_WIDTH - 1,
                 mpfb_pkg::DISPLAY_HEIGHT - 1, 0, 0, mpfb_pkg::COLOR_BLACK));
    send_cmd(cmd(mpfb_pkg::KIND_HLINE, 0, 20, 10, 0, COLOR_NONE));        // draws nothing
    send_cmd(cmd(mpfb_pkg::KIND_READ, 200, 0, 0, 0, mpfb_pkg::COLOR_BLACK)); // out of range
    send_cmd(cmd(mpfb_pkg::KIND_READ, 0, -1, 0, 0, mpfb_pkg::COLOR_BLACK));
    send_cmd(cmd(KIND_SPARE_6, 1, 1, 1, 1, mpfb_pkg::COLOR_WHITE));
    send_cmd(cmd(KIND_SPARE_7, 1, 1, 1, 1, mpfb_pkg::COLOR_WHITE));
    send_cmd(cmd(mpfb_pkg::KIND_FILL, 0, 0, 0, 0, mpfb_pkg::COLOR_INVERSE)); // all ones
    send_cmd(cmd(mpfb_pkg::KIND_HLINE, -32768, 0, 32767, 0, mpfb_pkg::COLOR_BLACK));
    send_cmd(cmd(mpfb_pkg::KIND_HLINE, 0, 7, 32767, 0, mpfb_pkg::COLOR_BLACK));
    send_cmd(cmd(mpfb_pkg::KIND_READ, 5, 0, 0, 0, mpfb_pkg::COLOR_BLACK));
    send_cmd(cmd(mpfb_pkg::KIND_FILL, 0, 0, 0, 0, mpfb_pkg::COLOR_BLACK));
    settle();

    // Random phases, invert toggled between them.
    for (int phase = 0; phase < 4; phase++) begin
      write_invert(phase % 2 == 0);
      for (int n = 0; n < 200; n++) begin
        if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        send_cmd(random_cmd());
      end
      settle();
    end

    if (model.pending() != 0) begin
      $error("read_data: expected %0d more results, actual none", model.pending());
      model.errors++;
    end
    if (model.errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  // Timeout well past the slowest legal run.
  initial begin
    #10_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
